@@ sv/complex_arith_unit_top_defines.svh @@
// ----------------------------------------------------------------------------
// complex_arith_unit_top_defines.svh
// Assertion macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_TOP_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CAU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define CAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// Types and constants of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FIELD_BITS = 32;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]                   op;
    logic signed [FIELD_BITS-1:0] a_real;
    logic signed [FIELD_BITS-1:0] a_imag;
    logic signed [FIELD_BITS-1:0] b_real;
    logic signed [FIELD_BITS-1:0] b_imag;
  } cmd_item_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] res_real;
    logic signed [FIELD_BITS-1:0] res_imag;
    logic                         saturated;
    logic                         divide_by_zero;
  } res_item_t;

  // control travelling with each item down the pipeline
  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic       neg_re;
    logic       neg_im;
    logic       ovf_re;
    logic       ovf_im;
    logic       dz;
  } ctl_t;

endpackage

@@ sv/cau_front.sv @@
// ----------------------------------------------------------------------------
// cau_front
// Five stages: operand capture, products, sums, magnitudes, and the
// per-operation preparation of the magnitude or of the divider.
// ----------------------------------------------------------------------------
module cau_front #(
  parameter int EW = 32,
  parameter int EF = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               cmd_valid,
  input  cau_pkg::cmd_item_t cmd,
  output cau_pkg::ctl_t      ctl,
  output logic [2*EW-1:0]    den,
  output logic [2*EW-1:0]    rem_re,
  output logic [2*EW-1:0]    rem_im,
  output logic [EW:0]        nlow_re,
  output logic [EW:0]        nlow_im,
  output logic [EW:0]        q_re,
  output logic [EW:0]        q_im
);

  localparam int MW = 2 * EW;
  localparam int AW = EW + 1;
  localparam int SW = MW + 1;
  localparam int CW = MW + EW + EF + 2;
  localparam logic [CW-1:0] HALF = (EF > 0) ? (CW'(1) << ((EF > 0) ? EF - 1 : 0)) : '0;
  localparam logic [CW-1:0] QMAX = CW'(1) << EW;

  // stage 1
  logic                 v1;
  logic [1:0]           op1;
  logic signed [EW-1:0] ar1, ai1, br1, bi1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= cmd_valid;
    end
    if (en) begin
      op1 <= cmd.op;
      ar1 <= cmd.a_real[EW-1:0];
      ai1 <= cmd.a_imag[EW-1:0];
      br1 <= cmd.b_real[EW-1:0];
      bi1 <= cmd.b_imag[EW-1:0];
    end
  end

  // stage 2
  logic                 v2;
  logic [1:0]           op2;
  logic signed [MW-1:0] p_rr, p_ii, p_ri, p_ir, p_bbr, p_bbi;
  logic signed [AW-1:0] as_re, as_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      op2   <= op1;
      p_rr  <= MW'(ar1) * MW'(br1);
      p_ii  <= MW'(ai1) * MW'(bi1);
      p_ri  <= MW'(ar1) * MW'(bi1);
      p_ir  <= MW'(ai1) * MW'(br1);
      p_bbr <= MW'(br1) * MW'(br1);
      p_bbi <= MW'(bi1) * MW'(bi1);
      if (op1 == cau_pkg::OP_SUB) begin
        as_re <= AW'(ar1) - AW'(br1);
        as_im <= AW'(ai1) - AW'(bi1);
      end else begin
        as_re <= AW'(ar1) + AW'(br1);
        as_im <= AW'(ai1) + AW'(bi1);
      end
    end
  end

  // stage 3
  logic                 v3;
  logic [1:0]           op3;
  logic                 dz3;
  logic signed [SW-1:0] s_re, s_im;
  logic [MW-1:0]        den3;
  logic signed [SW-1:0] s_re_next, s_im_next;
  logic                 bzero;

  always_comb begin
    bzero = (p_bbr == '0) && (p_bbi == '0);
    case (op2)
      cau_pkg::OP_MUL: begin
        s_re_next = SW'(p_rr) - SW'(p_ii);
        s_im_next = SW'(p_ri) + SW'(p_ir);
      end
      cau_pkg::OP_DIV: begin
        s_re_next = SW'(p_rr) + SW'(p_ii);
        s_im_next = SW'(p_ir) - SW'(p_ri);
      end
      default: begin
        s_re_next = SW'(as_re);
        s_im_next = SW'(as_im);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      op3  <= op2;
      s_re <= s_re_next;
      s_im <= s_im_next;
      dz3  <= (op2 == cau_pkg::OP_DIV) && bzero;
      den3 <= bzero ? MW'(1) : ($unsigned(p_bbr) + $unsigned(p_bbi));
    end
  end

  // stage 4
  logic          v4;
  logic [1:0]    op4;
  logic          dz4, neg4_re, neg4_im;
  logic [MW-1:0] mag_re, mag_im, den4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      op4     <= op3;
      dz4     <= dz3;
      den4    <= den3;
      neg4_re <= s_re[MW];
      neg4_im <= s_im[MW];
      mag_re  <= MW'(s_re[MW] ? -s_re : s_re);
      mag_im  <= MW'(s_im[MW] ? -s_im : s_im);
    end
  end

  // stage 5
  logic [CW-1:0] t_re, t_im, n_re, n_im, dfull;
  logic [EW:0]   q_re_next, q_im_next;
  logic          ovf_re_next, ovf_im_next;

  always_comb begin
    t_re  = (CW'(mag_re) + HALF) >> EF;
    t_im  = (CW'(mag_im) + HALF) >> EF;
    n_re  = CW'(mag_re) << (EF + 1);
    n_im  = CW'(mag_im) << (EF + 1);
    dfull = CW'(den4) << (EW + 1);
    ovf_re_next = 1'b0;
    ovf_im_next = 1'b0;
    case (op4)
      cau_pkg::OP_MUL: begin
        q_re_next = (t_re > QMAX) ? QMAX[EW:0] : t_re[EW:0];
        q_im_next = (t_im > QMAX) ? QMAX[EW:0] : t_im[EW:0];
      end
      cau_pkg::OP_DIV: begin
        q_re_next   = '0;
        q_im_next   = '0;
        ovf_re_next = n_re >= dfull;
        ovf_im_next = n_im >= dfull;
      end
      default: begin
        q_re_next = mag_re[EW:0];
        q_im_next = mag_im[EW:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= v4;
    end
    if (en) begin
      ctl.op     <= op4;
      ctl.neg_re <= neg4_re;
      ctl.neg_im <= neg4_im;
      ctl.ovf_re <= ovf_re_next;
      ctl.ovf_im <= ovf_im_next;
      ctl.dz     <= dz4;
      den        <= den4;
      rem_re     <= MW'(n_re >> (EW + 1));
      rem_im     <= MW'(n_im >> (EW + 1));
      nlow_re    <= n_re[EW:0];
      nlow_im    <= n_im[EW:0];
      q_re       <= q_re_next;
      q_im       <= q_im_next;
    end
  end

endmodule

@@ sv/cau_div_stage.sv @@
// ----------------------------------------------------------------------------
// cau_div_stage
// One restoring division step for both parts; other operations pass.
// ----------------------------------------------------------------------------
module cau_div_stage #(
  parameter int EW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  cau_pkg::ctl_t   ctl_in,
  input  logic [2*EW-1:0] den_in,
  input  logic [2*EW-1:0] rem_re_in,
  input  logic [2*EW-1:0] rem_im_in,
  input  logic [EW:0]     nlow_re_in,
  input  logic [EW:0]     nlow_im_in,
  input  logic [EW:0]     q_re_in,
  input  logic [EW:0]     q_im_in,
  output cau_pkg::ctl_t   ctl,
  output logic [2*EW-1:0] den,
  output logic [2*EW-1:0] rem_re,
  output logic [2*EW-1:0] rem_im,
  output logic [EW:0]     nlow_re,
  output logic [EW:0]     nlow_im,
  output logic [EW:0]     q_re,
  output logic [EW:0]     q_im
);

  localparam int MW = 2 * EW;

  logic [MW:0]   r2_re, r2_im, d2;
  logic          ge_re, ge_im, is_div;

  always_comb begin
    is_div = ctl_in.op == cau_pkg::OP_DIV;
    r2_re  = {rem_re_in, nlow_re_in[EW]};
    r2_im  = {rem_im_in, nlow_im_in[EW]};
    d2     = {1'b0, den_in};
    ge_re  = r2_re >= d2;
    ge_im  = r2_im >= d2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl.op     <= ctl_in.op;
      ctl.neg_re <= ctl_in.neg_re;
      ctl.neg_im <= ctl_in.neg_im;
      ctl.ovf_re <= ctl_in.ovf_re;
      ctl.ovf_im <= ctl_in.ovf_im;
      ctl.dz     <= ctl_in.dz;
      den        <= den_in;
      nlow_re    <= {nlow_re_in[EW-1:0], 1'b0};
      nlow_im    <= {nlow_im_in[EW-1:0], 1'b0};
      if (is_div) begin
        rem_re <= ge_re ? MW'(r2_re - d2) : r2_re[MW-1:0];
        rem_im <= ge_im ? MW'(r2_im - d2) : r2_im[MW-1:0];
        q_re   <= {q_re_in[EW-1:0], ge_re};
        q_im   <= {q_im_in[EW-1:0], ge_im};
      end else begin
        rem_re <= rem_re_in;
        rem_im <= rem_im_in;
        q_re   <= q_re_in;
        q_im   <= q_im_in;
      end
    end
  end

endmodule

@@ sv/cau_back.sv @@
// ----------------------------------------------------------------------------
// cau_back
// Quotient rounding, saturation to the word range and result assembly.
// ----------------------------------------------------------------------------
module cau_back #(
  parameter int EW = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  cau_pkg::ctl_t      ctl_in,
  input  logic [EW:0]        q_re,
  input  logic [EW:0]        q_im,
  output logic               res_valid,
  output cau_pkg::res_item_t res
);

  localparam logic [EW:0] POS_LIM = {2'b00, {(EW - 1){1'b1}}};
  localparam logic [EW:0] NEG_LIM = {2'b01, {(EW - 1){1'b0}}};

  logic [EW+1:0]        inc_re, inc_im;
  logic [EW:0]          m_re, m_im, lim_re, lim_im;
  logic                 s_re, s_im, is_div;
  logic signed [EW-1:0] v_re, v_im;

  always_comb begin
    is_div = ctl_in.op == cau_pkg::OP_DIV;
    inc_re = {1'b0, q_re} + 1'b1;
    inc_im = {1'b0, q_im} + 1'b1;
    m_re   = is_div ? inc_re[EW+1:1] : q_re;
    m_im   = is_div ? inc_im[EW+1:1] : q_im;
    lim_re = ctl_in.neg_re ? NEG_LIM : POS_LIM;
    lim_im = ctl_in.neg_im ? NEG_LIM : POS_LIM;
    s_re   = ctl_in.ovf_re || (m_re > lim_re);
    s_im   = ctl_in.ovf_im || (m_im > lim_im);
    if (s_re) begin
      m_re = lim_re;
    end
    if (s_im) begin
      m_im = lim_im;
    end
    v_re = ctl_in.neg_re ? EW'(-m_re) : EW'(m_re);
    v_im = ctl_in.neg_im ? EW'(-m_im) : EW'(m_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= ctl_in.valid;
    end
    if (en) begin
      res.res_real       <= cau_pkg::FIELD_BITS'(v_re);
      res.res_imag       <= cau_pkg::FIELD_BITS'(v_im);
      res.saturated      <= s_re | s_im;
      res.divide_by_zero <= ctl_in.dz;
    end
  end

endmodule

@@ sv/complex_arith_unit_top.sv @@
// ----------------------------------------------------------------------------
// complex_arith_unit_top
// Complex add, subtract, multiply and divide on signed fixed-point parts.
// ----------------------------------------------------------------------------
// One item is taken every cycle while cmd_ready is high; every operation
// runs through the same stages, so results leave in order. The divider
// forms one quotient bit per stage over EW + 1 stages, behind five stages
// of products, sums and set-up, then a rounding stage and the output
// register. A skid register behind the output keeps the input open for one
// more item while a result waits to be taken. Divide uses a * conj(b) /
// |b|^2 rounded to nearest; a zero |b|^2 gives a zero result with
// divide_by_zero set.
// ----------------------------------------------------------------------------
module complex_arith_unit_top #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cau_pkg::cmd_item_t cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output cau_pkg::res_item_t res
);

  localparam int EW = (WORD_BITS > 32) ? 32 : WORD_BITS;
  localparam int EF = (FRAC_BITS > 31) ? 31 : FRAC_BITS;
  localparam int MW = 2 * EW;
  localparam int NS = EW + 1;

  logic en;

  cau_pkg::ctl_t ch_ctl     [0:NS];
  logic [MW-1:0] ch_den     [0:NS];
  logic [MW-1:0] ch_rem_re  [0:NS];
  logic [MW-1:0] ch_rem_im  [0:NS];
  logic [EW:0]   ch_nlow_re [0:NS];
  logic [EW:0]   ch_nlow_im [0:NS];
  logic [EW:0]   ch_q_re    [0:NS];
  logic [EW:0]   ch_q_im    [0:NS];

  logic               p_valid;
  cau_pkg::res_item_t p_res;
  logic               skid_valid;
  cau_pkg::res_item_t skid;

  assign en        = !skid_valid;
  assign cmd_ready = en;

  cau_front #(.EW(EW), .EF(EF)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .ctl       (ch_ctl[0]),
    .den       (ch_den[0]),
    .rem_re    (ch_rem_re[0]),
    .rem_im    (ch_rem_im[0]),
    .nlow_re   (ch_nlow_re[0]),
    .nlow_im   (ch_nlow_im[0]),
    .q_re      (ch_q_re[0]),
    .q_im      (ch_q_im[0])
  );

  for (genvar i = 0; i < NS; i++) begin : g_div
    cau_div_stage #(.EW(EW)) u_stage (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .ctl_in     (ch_ctl[i]),
      .den_in     (ch_den[i]),
      .rem_re_in  (ch_rem_re[i]),
      .rem_im_in  (ch_rem_im[i]),
      .nlow_re_in (ch_nlow_re[i]),
      .nlow_im_in (ch_nlow_im[i]),
      .q_re_in    (ch_q_re[i]),
      .q_im_in    (ch_q_im[i]),
      .ctl        (ch_ctl[i+1]),
      .den        (ch_den[i+1]),
      .rem_re     (ch_rem_re[i+1]),
      .rem_im     (ch_rem_im[i+1]),
      .nlow_re    (ch_nlow_re[i+1]),
      .nlow_im    (ch_nlow_im[i+1]),
      .q_re       (ch_q_re[i+1]),
      .q_im       (ch_q_im[i+1])
    );
  end

  cau_back #(.EW(EW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ctl_in    (ch_ctl[NS]),
    .q_re      (ch_q_re[NS]),
    .q_im      (ch_q_im[NS]),
    .res_valid (p_valid),
    .res       (p_res)
  );

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= p_valid;
      end
    end else if (p_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || res_ready) begin
      res <= skid_valid ? skid : p_res;
    end else if (!skid_valid) begin
      skid <= p_res;
    end
  end

endmodule

@@ sv/cau_checker.sv @@
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks on the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "complex_arith_unit_top_defines.svh"

module cau_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_ready,
  input logic               res_valid,
  input logic               res_ready,
  input cau_pkg::res_item_t res
);

  `CAU_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res),
                   "result item changed while stalled")
  `CAU_ASSERT_NOW(a_dz_zero, res_valid && res.divide_by_zero,
                  res.res_real == 0 && res.res_imag == 0 && !res.saturated,
                  "zero divisor gave non-zero result")
  `CAU_ASSERT_NOW(a_ready_low, !cmd_ready, res_valid, "input closed with no result waiting")
  `CAU_ASSERT_NOW(a_ready_fall, $fell(cmd_ready), $past(res_valid && !res_ready),
                  "input closed without output stall")

endmodule

bind complex_arith_unit_top cau_checker u_cau_checker (.*);
